// ----- design/ibp_pkg.sv -----
package ibp_pkg;

  // Sample and batch sizing
  localparam int SAMPLE_W   = 16;
  localparam int MAX_BATCH  = 4096;
  localparam int TALLY_W    = 13;
  localparam int SQUARE_W   = 31;
  localparam int E_W        = 32;
  localparam int SUM_W      = 44;

  // log2 in unsigned Q.16: 6-bit leading-one position, 16 fraction bits
  localparam int LOG_FRAC_BITS = 6;
  localparam int TAB_SIZE      = 1 << LOG_FRAC_BITS;
  localparam int FRAC_W        = 16;
  localparam int POS_W         = 6;
  localparam int LOG_W         = POS_W + FRAC_W;
  localparam int GRP_W         = 8;
  localparam int GRP_N         = 6;
  localparam int GRP_SEL_W     = 3;
  localparam int GRP_POS_W     = 3;

  // dB conversion
  localparam int DIFF_W      = 24;
  localparam int SCALE_W     = 19;
  localparam int PROD_W      = 44;
  localparam int POWER_W     = 16;
  localparam int LOG2_FS_Q16 = 1966074;
  localparam int DB_SCALE    = 197283;
  localparam int ROUND_HALF  = 1 << 23;
  localparam int ROUND_SHIFT = 24;
  localparam int POWER_MIN   = -32768;
  localparam int POWER_MAX   = 1023;

  // Side data stages: two log2 stages and a table stage, subtract, multiply
  localparam int META_DEPTH  = 5;

  localparam logic [SUM_W-1:0] ENERGY_MAX = {SUM_W{1'b1}};

  typedef logic [FRAC_W-1:0] frac_tab_t [TAB_SIZE];

  // Closed batch as it leaves the accumulator
  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [TALLY_W-1:0] tally;
  } batch_t;

  // Per-result side data that rides along the log pipeline
  typedef struct packed {
    logic               valid;
    logic               no_power;
    logic [TALLY_W-1:0] tally;
  } meta_t;

  // Build log2(1 + k/2^LOG_FRAC_BITS) by repeated squaring of a Q1.31 mantissa
  function automatic frac_tab_t build_frac_tab();
    frac_tab_t   tab;
    logic [63:0] m;
    logic [FRAC_W-1:0] frac;
    for (int k = 0; k < TAB_SIZE; k++) begin
      m    = 64'((TAB_SIZE + k)) << (31 - LOG_FRAC_BITS);
      frac = '0;
      for (int i = 0; i < FRAC_W; i++) begin
        m    = (m * m) >> 31;
        frac = frac << 1;
        if (m >= (64'd1 << 32)) begin
          frac[0] = 1'b1;
          m       = m >> 1;
        end
      end
      tab[k] = frac;
    end
    return tab;
  endfunction

  localparam frac_tab_t FRAC_TAB = build_frac_tab();

endpackage

// ----- design/ibp_in_if.sv -----
interface ibp_in_if;
  import ibp_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] in_phase;
  logic signed [SAMPLE_W-1:0] quadrature;
  logic                       has_sample;
  logic                       last_sample;

  modport source (
    output valid, in_phase, quadrature, has_sample, last_sample,
    input  ready
  );
  modport sink (
    input  valid, in_phase, quadrature, has_sample, last_sample,
    output ready
  );
endinterface

// ----- design/ibp_out_if.sv -----
interface ibp_out_if;
  import ibp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [POWER_W-1:0] power_db;
  logic                      no_power;
  logic [TALLY_W-1:0]        batch_samples;

  modport source (
    output valid, power_db, no_power, batch_samples,
    input  ready
  );
  modport sink (
    input  valid, power_db, no_power, batch_samples,
    output ready
  );
endinterface

// ----- design/iq_batch_power_dbfs_top.sv -----
// channel  | dir | payload                                     | transfer
// in_ch    | in  | in_phase, quadrature, has_sample, last_sample| valid & ready
// out_ch   | out | power_db, no_power, batch_samples            | valid & ready
//
// One sample transfer per cycle; in_ch.ready is low only while a result waits.
// A result follows the transfer that closes its batch through the square,
// accumulate, leading-one, table, subtract and multiply stages.
// Reset (rst_n low, synchronous) empties the pipeline and clears the batch sum.
// A stalled result holds the whole pipeline, accumulator included.
module iq_batch_power_dbfs_top (
  input  logic       clk,
  input  logic       rst_n,
  ibp_in_if.sink     in_ch,
  ibp_out_if.source  out_ch
);
  import ibp_pkg::*;

  logic                      en;
  logic                      fin_valid;
  batch_t                    fin;
  logic [LOG_W-1:0]          log_sum, log_cnt;
  logic signed [POWER_W-1:0] power;
  meta_t                     meta_r [META_DEPTH];
  meta_t                     meta_in;
  logic                      out_valid_r;
  logic signed [POWER_W-1:0] power_r;
  logic                      no_power_r;
  logic [TALLY_W-1:0]        samples_r;

  // Advance everything whenever the result register can take a value
  assign en = !out_valid_r || out_ch.ready;

  ibp_energy u_energy (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_ch     (in_ch),
    .fin_valid (fin_valid),
    .fin       (fin)
  );

  ibp_log2 u_log_sum (
    .clk     (clk),
    .en      (en),
    .x       (fin.sum),
    .log_q16 (log_sum)
  );

  ibp_log2 u_log_cnt (
    .clk     (clk),
    .en      (en),
    .x       (SUM_W'(fin.tally)),
    .log_q16 (log_cnt)
  );

  ibp_db u_db (
    .clk     (clk),
    .en      (en),
    .log_sum (log_sum),
    .log_cnt (log_cnt),
    .power   (power)
  );

  // Flag empty or silent batches next to the log pipeline
  always_comb begin
    meta_in.valid    = fin_valid;
    meta_in.no_power = (fin.tally == '0) || (fin.sum == '0);
    meta_in.tally    = fin.tally;
  end

  // Advance side data alongside the log pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < META_DEPTH; i++) meta_r[i].valid <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      meta_r[0] <= meta_in;
      for (int i = 1; i < META_DEPTH; i++) meta_r[i] <= meta_r[i-1];
      out_valid_r <= meta_r[META_DEPTH-1].valid;
    end
  end

  // Hold the result payload through stalls
  always_ff @(posedge clk) begin
    if (en) begin
      no_power_r <= meta_r[META_DEPTH-1].no_power;
      samples_r  <= meta_r[META_DEPTH-1].tally;
      power_r    <= meta_r[META_DEPTH-1].no_power ? POWER_W'(POWER_MIN) : power;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.power_db      = power_r;
  assign out_ch.no_power      = no_power_r;
  assign out_ch.batch_samples = samples_r;
endmodule

// ----- design/ibp_energy.sv -----
module ibp_energy (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  ibp_in_if.sink            in_ch,
  output logic              fin_valid,
  output ibp_pkg::batch_t   fin
);
  import ibp_pkg::*;

  logic                       v0_r, v1_r, v2_r, fin_v_r;
  logic signed [SAMPLE_W-1:0] i_r, q_r;
  logic                       has0_r, last0_r, has1_r, last1_r, has2_r, last2_r;
  logic [SQUARE_W-1:0]        isq_r, qsq_r;
  logic [E_W-1:0]             e_r;
  logic [SUM_W-1:0]           sum_r, sum_nxt;
  logic [TALLY_W-1:0]         tally_r, tally_nxt;
  batch_t                     fin_r;
  logic                       take;
  logic [SUM_W:0]             sum_wide;
  logic signed [2*SAMPLE_W-1:0] isq_full, qsq_full;

  assign in_ch.ready = en;

  // Square the components of the registered sample
  assign isq_full = i_r * i_r;
  assign qsq_full = q_r * q_r;

  // Add the new energy while the tally is below MAX_BATCH, saturating at the top of the sum
  assign take     = v2_r && has2_r && (tally_r < TALLY_W'(MAX_BATCH));
  assign sum_wide = {1'b0, sum_r} + (SUM_W+1)'(e_r);
  always_comb begin
    sum_nxt   = sum_r;
    tally_nxt = tally_r;
    if (take) begin
      sum_nxt   = (sum_wide > (SUM_W+1)'(ENERGY_MAX)) ? ENERGY_MAX : sum_wide[SUM_W-1:0];
      tally_nxt = tally_r + TALLY_W'(1);
    end
  end

  // Advance valid bits on each step of the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      fin_v_r <= 1'b0;
      sum_r   <= '0;
      tally_r <= '0;
    end else if (en) begin
      v0_r    <= in_ch.valid;
      v1_r    <= v0_r;
      v2_r    <= v1_r;
      fin_v_r <= v2_r && last2_r;
      if (v2_r && last2_r) begin
        sum_r   <= '0;
        tally_r <= '0;
      end else begin
        sum_r   <= sum_nxt;
        tally_r <= tally_nxt;
      end
    end
  end

  // Hold payload through stalls
  always_ff @(posedge clk) begin
    if (en) begin
      i_r     <= in_ch.in_phase;
      q_r     <= in_ch.quadrature;
      has0_r  <= in_ch.has_sample;
      last0_r <= in_ch.last_sample;
      isq_r   <= SQUARE_W'(isq_full);
      qsq_r   <= SQUARE_W'(qsq_full);
      has1_r  <= has0_r;
      last1_r <= last0_r;
      e_r     <= E_W'(isq_r) + E_W'(qsq_r);
      has2_r  <= has1_r;
      last2_r <= last1_r;
      if (v2_r && last2_r) begin
        fin_r.sum   <= sum_nxt;
        fin_r.tally <= tally_nxt;
      end
    end
  end

  assign fin_valid = fin_v_r;
  assign fin       = fin_r;
endmodule

// ----- design/ibp_log2.sv -----
module ibp_log2 (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ibp_pkg::SUM_W-1:0]   x,
  output logic [ibp_pkg::LOG_W-1:0]   log_q16
);
  import ibp_pkg::*;

  logic [GRP_W*GRP_N-1:0]  x_pad;
  logic [GRP_N-1:0]        nz, nz_r;
  logic [GRP_POS_W-1:0]    pos [GRP_N];
  logic [GRP_POS_W-1:0]    pos_r [GRP_N];
  logic [SUM_W-1:0]        x_r;
  logic [GRP_SEL_W-1:0]    gsel;
  logic [POS_W-1:0]        p, p_r;
  logic [SUM_W+LOG_FRAC_BITS-1:0] x_shift;
  logic [LOG_FRAC_BITS-1:0] k, k_r;
  logic [LOG_W-1:0]        log_r;

  // Find the leading one inside each byte
  assign x_pad = (GRP_W*GRP_N)'(x);
  always_comb begin
    for (int g = 0; g < GRP_N; g++) begin
      nz[g]  = |x_pad[g*GRP_W +: GRP_W];
      pos[g] = '0;
      for (int b = 0; b < GRP_W; b++) begin
        if (x_pad[g*GRP_W + b]) pos[g] = GRP_POS_W'(b);
      end
    end
  end

  // Pick the top nonzero byte and take the bits just below the leading one
  always_comb begin
    gsel = '0;
    for (int g = 0; g < GRP_N; g++) begin
      if (nz_r[g]) gsel = GRP_SEL_W'(g);
    end
    p       = {gsel, pos_r[gsel]};
    x_shift = {x_r, {LOG_FRAC_BITS{1'b0}}} >> p;
    k       = x_shift[LOG_FRAC_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x;
      nz_r  <= nz;
      pos_r <= pos;
      p_r   <= p;
      k_r   <= k;
      log_r <= {p_r, FRAC_TAB[k_r]};
    end
  end

  assign log_q16 = log_r;
endmodule

// ----- design/ibp_db.sv -----
module ibp_db (
  input  logic                              clk,
  input  logic                              en,
  input  logic [ibp_pkg::LOG_W-1:0]         log_sum,
  input  logic [ibp_pkg::LOG_W-1:0]         log_cnt,
  output logic signed [ibp_pkg::POWER_W-1:0] power
);
  import ibp_pkg::*;

  logic signed [DIFF_W-1:0] d_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] rounded_full;
  logic signed [PROD_W-ROUND_SHIFT-1:0] rounded;

  // Difference of logs less full scale, then scale to 1/256 dB
  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= DIFF_W'(log_sum) - DIFF_W'(log_cnt) - DIFF_W'(LOG2_FS_Q16);
      prod_r <= PROD_W'(d_r) * $signed(PROD_W'(DB_SCALE));
    end
  end

  // Round to nearest by floor of half-offset value, then clamp
  assign rounded_full = (prod_r + PROD_W'(ROUND_HALF)) >>> ROUND_SHIFT;
  assign rounded      = rounded_full[PROD_W-ROUND_SHIFT-1:0];
  always_comb begin
    if (rounded < (PROD_W-ROUND_SHIFT)'(POWER_MIN)) begin
      power = POWER_W'(POWER_MIN);
    end else if (rounded > (PROD_W-ROUND_SHIFT)'(POWER_MAX)) begin
      power = POWER_W'(POWER_MAX);
    end else begin
      power = rounded[POWER_W-1:0];
    end
  end
endmodule

// ----- sim/tb.sv -----
module tb;
  import ibp_pkg::*;

  typedef struct {
    logic signed [SAMPLE_W-1:0] i_val;
    logic signed [SAMPLE_W-1:0] q_val;
    bit                         has;
    bit                         last;
  } iq_item_t;

  typedef struct {
    logic signed [POWER_W-1:0] power;
    bit                        no_power;
    logic [TALLY_W-1:0]        samples;
  } power_reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ibp_in_if  in_if ();
  ibp_out_if out_if ();

  iq_batch_power_dbfs_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  iq_item_t       sample_queue [$];
  power_reading_t expected_readings [$];

  // Running batch as the hardware should see it
  logic [SUM_W-1:0]   batch_energy = '0;
  logic [TALLY_W-1:0] batch_count  = '0;

  int err_count     = 0;
  int in_transfers  = 0;
  int readings_seen = 0;
  int no_power_seen = 0;
  int biggest_batch = 0;
  int gap_left      = 0;
  int stall_left    = 0;
  bit calm_in       = 1'b0;
  bit calm_out      = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Known values on every input before the first edge
  initial begin
    in_if.valid       = 1'b0;
    in_if.in_phase    = '0;
    in_if.quadrature  = '0;
    in_if.has_sample  = 1'b0;
    in_if.last_sample = 1'b0;
    out_if.ready      = 1'b0;
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Unsigned Q.16 log2: leading-one position plus a squared-mantissa fraction
  function automatic longint log2_fixed(logic [63:0] x);
    int                    p;
    longint unsigned       k;
    longint unsigned       m;
    logic [FRAC_W-1:0]     frac;
    p = 0;
    for (int b = 0; b < 64; b++)
      if (x[b]) p = b;
    if (p >= LOG_FRAC_BITS)
      k = (x >> (p - LOG_FRAC_BITS)) & ((64'd1 << LOG_FRAC_BITS) - 1);
    else
      k = (x << (LOG_FRAC_BITS - p)) & ((64'd1 << LOG_FRAC_BITS) - 1);
    m = ((64'd1 << LOG_FRAC_BITS) + k) << (31 - LOG_FRAC_BITS);
    frac = '0;
    for (int i = 0; i < FRAC_W; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return longint'(p) * 65536 + longint'(frac);
  endfunction

  // Fold one accepted transfer into the batch; close it on last
  task automatic take_transfer(input iq_item_t it);
    longint         iv;
    longint         qv;
    logic [SUM_W:0] grown;
    longint         diff;
    longint         prod;
    longint         pw;
    power_reading_t rd;
    if (it.has && batch_count < MAX_BATCH) begin
      iv = it.i_val;
      qv = it.q_val;
      grown = {1'b0, batch_energy} + (SUM_W+1)'(iv * iv + qv * qv);
      batch_energy = grown[SUM_W] ? ENERGY_MAX : grown[SUM_W-1:0];
      batch_count = batch_count + 1'b1;
    end
    if (it.last) begin
      if (batch_count == 0 || batch_energy == 0) begin
        rd.power = POWER_MIN;
        rd.no_power = 1'b1;
      end else begin
        diff = log2_fixed(64'(batch_energy)) - log2_fixed(64'(batch_count)) - LOG2_FS_Q16;
        prod = diff * DB_SCALE;
        pw = (prod + ROUND_HALF) >>> ROUND_SHIFT;
        if (pw < POWER_MIN) pw = POWER_MIN;
        if (pw > POWER_MAX) pw = POWER_MAX;
        rd.power = pw[POWER_W-1:0];
        rd.no_power = 1'b0;
      end
      rd.samples = batch_count;
      expected_readings.push_back(rd);
      if (batch_count > biggest_batch) biggest_batch = batch_count;
      batch_energy = '0;
      batch_count = '0;
    end
  endtask

  // Driver: hold the item until transfer, then idle or advance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        take_transfer(sample_queue.pop_front());
        in_transfers++;
        if ($urandom_range(0, 299) == 0) calm_in = !calm_in;
        gap_left = calm_in ? 0 : pick_gap();
      end
      if (in_if.valid && !in_if.ready) begin
        // hold the current item
      end else if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (sample_queue.size() > 0) begin
        in_if.valid       <= 1'b1;
        in_if.in_phase    <= sample_queue[0].i_val;
        in_if.quadrature  <= sample_queue[0].q_val;
        in_if.has_sample  <= sample_queue[0].has;
        in_if.last_sample <= sample_queue[0].last;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: check each reading transfer, stall the result side at random
  always @(posedge clk) begin
    power_reading_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        readings_seen++;
        if (expected_readings.size() == 0) begin
          $error("reading arrived with none expected: power_db %0d", out_if.power_db);
          err_count++;
        end else begin
          want = expected_readings.pop_front();
          if (want.no_power) no_power_seen++;
          if (out_if.power_db !== want.power) begin
            $error("power_db: expected %0d, got %0d", want.power, out_if.power_db);
            err_count++;
          end
          if (out_if.no_power !== want.no_power) begin
            $error("no_power: expected %0d, got %0d", want.no_power, out_if.no_power);
            err_count++;
          end
          if (out_if.batch_samples !== want.samples) begin
            $error("batch_samples: expected %0d, got %0d", want.samples, out_if.batch_samples);
            err_count++;
          end
        end
      end
      if ($urandom_range(0, 299) == 0) calm_out = !calm_out;
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (!calm_out && $urandom_range(0, 5) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic add_item(input logic signed [SAMPLE_W-1:0] i_val,
                          input logic signed [SAMPLE_W-1:0] q_val,
                          input bit has, input bit last);
    iq_item_t it;
    it.i_val = i_val;
    it.q_val = q_val;
    it.has   = has;
    it.last  = last;
    sample_queue.push_back(it);
  endtask

  // Sample component: full range, small, extremes, zero, tiny
  function automatic logic signed [SAMPLE_W-1:0] rand_component();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return SAMPLE_W'($urandom);
    if (r < 7) return SAMPLE_W'($urandom_range(0, 511) - 256);
    if (r == 7) return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    if (r == 8) return '0;
    return SAMPLE_W'($urandom_range(0, 6) - 3);
  endfunction

  initial begin
    int counted;
    int len;
    int kind;
    logic signed [SAMPLE_W-1:0] iv;
    logic signed [SAMPLE_W-1:0] qv;

    // Directed: empty batch, extremes, zero batch, ignored fields
    add_item(16'sh1234, -16'sd77, 1'b0, 1'b1);
    add_item(16'sh8000, 16'sh8000, 1'b1, 1'b1);
    add_item(16'sh7FFF, 16'sh0000, 1'b1, 1'b1);
    add_item(16'sh0001, 16'sh0000, 1'b1, 1'b1);
    add_item(16'sh0000, -16'sd1, 1'b1, 1'b1);
    add_item(16'sh0000, 16'sh0000, 1'b1, 1'b0);
    add_item(16'sh0000, 16'sh0000, 1'b1, 1'b1);
    add_item(16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0);
    add_item(16'sh0003, 16'sh0004, 1'b1, 1'b0);
    add_item(16'sh8000, 16'sh8000, 1'b0, 1'b1);
    add_item(16'sh8000, 16'sh7FFF, 1'b1, 1'b0);
    add_item(16'sh7FFF, 16'sh8000, 1'b1, 1'b1);
    add_item(16'sh5555, 16'shAAAA, 1'b1, 1'b1);
    add_item(16'shAAAA, 16'sh5555, 1'b1, 1'b1);
    add_item(-16'sd1, -16'sd1, 1'b1, 1'b0);
    add_item(16'sh0000, 16'sh0000, 1'b0, 1'b1);
    add_item(16'sh0000, 16'sh0000, 1'b0, 1'b1);

    // Random batches: mostly well-formed, some zero, empty or with noise
    counted = 0;
    while (counted < 680) begin
      kind = $urandom_range(0, 99);
      len = $urandom_range(0, 99);
      if (len < 70) len = $urandom_range(1, 8);
      else if (len < 95) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 200);
      if (kind < 5) begin
        add_item(rand_component(), rand_component(), 1'b0, 1'b1);
        counted++;
      end else begin
        for (int n = 0; n < len; n++) begin
          if (kind < 12) begin
            iv = '0;
            qv = '0;
          end else begin
            iv = rand_component();
            qv = rand_component();
          end
          if ($urandom_range(0, 15) == 0)
            add_item(rand_component(), rand_component(), 1'b0, 1'b0);
          if (n == len - 1 && $urandom_range(0, 9) == 0) begin
            add_item(iv, qv, 1'b1, 1'b0);
            add_item(rand_component(), rand_component(), 1'b0, 1'b1);
            counted += 2;
          end else begin
            add_item(iv, qv, 1'b1, n == len - 1);
            counted++;
          end
        end
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: everything sent, every reading back, then let the pipe settle
    while (sample_queue.size() > 0 || expected_readings.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Sent %0d input transfers and checked %0d power readings.",
             in_transfers, readings_seen);
    $display("Readings flagged no power: %0d; largest batch: %0d samples.",
             no_power_seen, biggest_batch);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Watchdog against a hung handshake
  initial begin
    #8000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
